// ----- rtl/fcbs_pkg.sv -----
// Shared types, constants and CRC helper for the byte-stuffing packet framer.
package fcbs_pkg;

  // Framing characters.
  localparam logic [7:0] STX     = 8'h3E;
  localparam logic [7:0] DLE     = 8'h2F;
  localparam logic [7:0] ETX     = 8'h0D;
  localparam logic [7:0] ETX_SUB = ETX - 8'd1;

  // CRC-16/MODBUS.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Packet length limits.
  localparam int MAX_WORDS = 29;
  localparam int WCNT_W    = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CMD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUB  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WCNT = 2'd2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic [15:0]       word;
    logic              first;
    logic              last;
    logic [7:0]        cmd;
    logic [7:0]        sub;
    logic [WCNT_W-1:0] cnt;
  } job_t;

  // Fold one byte into the running CRC, one bit per step.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/fcbs_if.sv -----
// Valid/ready channel interfaces for input words, output bytes and configuration writes.
interface fcbs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink (input valid, input data_word, output ready);
endinterface

interface fcbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_end;

  modport source (output valid, output out_byte, output last_of_run, output frame_end,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input frame_end,
                output ready);
endinterface

interface fcbs_cfg_if;
  import fcbs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/crc_packet_framer_with_byte_stuffing_top.sv -----
// Top level of the byte-stuffing packet framer with CRC-16/MODBUS.
//
//   channel  | dir | payload                               | accepted when
//   ---------+-----+---------------------------------------+----------------------
//   in_ch    | in  | data_word (signed 16)                 | valid && ready
//   out_ch   | out | out_byte (8), last_of_run, frame_end  | valid && ready
//   cfg_ch   | in  | index (2), data (8)                   | valid && ready (always)
//
// Each request yields 2 to 16 output bytes; the back-end sequencer sends one byte
// per cycle while the output is ready, 2 to 4 of them for a word in the middle of
// a packet. The front end accepts a word per cycle while the two-entry queue has
// room. Reset is synchronous and active low; afterwards the registers hold command
// 86, subcommand 120 and word count 4. A stalled output holds its byte in the output
// register while the queue keeps taking requests until both of its entries are full.
module crc_packet_framer_with_byte_stuffing_top (
  input  logic        clk,
  input  logic        rst_n,
  fcbs_in_if.sink     in_ch,
  fcbs_out_if.source  out_ch,
  fcbs_cfg_if.sink    cfg_ch
);
  import fcbs_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  fcbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  fcbs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  fcbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/fcbs_front.sv -----
// Front end: configuration registers, word acceptance and packet position tracking.
module fcbs_front (
  input  logic              clk,
  input  logic              rst_n,
  fcbs_in_if.sink           in_ch,
  fcbs_cfg_if.sink          cfg_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output fcbs_pkg::job_t    push_job
);
  import fcbs_pkg::*;

  logic [7:0]        cmd_r, cmd_nxt;
  logic [7:0]        sub_r, sub_nxt;
  logic [WCNT_W-1:0] wcnt_r, wcnt_nxt;
  logic [WCNT_W-1:0] taken_r, taken_nxt;
  logic [WCNT_W-1:0] cnt_used;
  logic [WCNT_W-1:0] taken_inc;
  logic              is_first;
  logic              is_last;
  logic              accept;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cmd_nxt  = cmd_r;
    sub_nxt  = sub_r;
    wcnt_nxt = wcnt_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CMD:  cmd_nxt  = cfg_ch.data;
        REG_SUB:  sub_nxt  = cfg_ch.data;
        REG_WCNT: wcnt_nxt = cfg_ch.data[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Word count as used: zero acts as one, large values clip to the maximum.
  always_comb begin
    if (wcnt_r == '0) begin
      cnt_used = WCNT_W'(1);
    end else if (wcnt_r > WCNT_W'(MAX_WORDS)) begin
      cnt_used = WCNT_W'(MAX_WORDS);
    end else begin
      cnt_used = wcnt_r;
    end
  end

  // Classify the incoming word by its place in the packet.
  assign accept    = in_ch.valid && push_ready;
  assign is_first  = (taken_r == '0);
  assign taken_inc = taken_r + WCNT_W'(1);
  assign is_last   = (taken_inc >= cnt_used);
  assign taken_nxt = accept ? (is_last ? '0 : taken_inc) : taken_r;

  assign in_ch.ready    = push_ready;
  assign push_valid     = in_ch.valid;
  assign push_job.word  = 16'(unsigned'(in_ch.data_word));
  assign push_job.first = is_first;
  assign push_job.last  = is_last;
  assign push_job.cmd   = cmd_r;
  assign push_job.sub   = sub_r;
  assign push_job.cnt   = cnt_used;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= 8'd86;
      sub_r   <= 8'd120;
      wcnt_r  <= WCNT_W'(4);
      taken_r <= '0;
    end else begin
      cmd_r   <= cmd_nxt;
      sub_r   <= sub_nxt;
      wcnt_r  <= wcnt_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule

// ----- rtl/fcbs_queue.sv -----
// Short request queue between the front end and the byte sequencer.
module fcbs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  fcbs_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fcbs_pkg::job_t pop_job
);
  import fcbs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/fcbs_back.sv -----
// Back end: byte sequencer with escaping, CRC accumulation and the output register.
module fcbs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  fcbs_pkg::job_t pop_job,
  fcbs_out_if.source     out_ch
);
  import fcbs_pkg::*;

  typedef enum logic [8:0] {
    S_STX  = 9'b000000001,
    S_CMD  = 9'b000000010,
    S_SUB  = 9'b000000100,
    S_CNT  = 9'b000001000,
    S_LO   = 9'b000010000,
    S_HI   = 9'b000100000,
    S_CRCL = 9'b001000000,
    S_CRCH = 9'b010000000,
    S_ETX  = 9'b100000000
  } step_t;

  step_t       step_r, step_nxt;
  job_t        job_r, job_nxt;
  logic        busy_r, busy_nxt;
  logic        esc_r, esc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_end_r, out_end_nxt;

  logic [7:0]  cur_raw;
  logic        stuffable;
  logic        special;
  logic        need_esc;
  logic        can_emit;
  logic        advance;
  logic        finishing;
  step_t       step_after;

  // Raw frame byte for the current step.
  always_comb begin
    unique case (step_r)
      S_STX:   cur_raw = STX;
      S_CMD:   cur_raw = job_r.cmd;
      S_SUB:   cur_raw = job_r.sub;
      S_CNT:   cur_raw = 8'(job_r.cnt);
      S_LO:    cur_raw = job_r.word[7:0];
      S_HI:    cur_raw = job_r.word[15:8];
      S_CRCL:  cur_raw = crc_r[7:0];
      S_CRCH:  cur_raw = crc_r[15:8];
      S_ETX:   cur_raw = ETX;
      default: cur_raw = '0;
    endcase
  end

  // Step that follows the current one within a request.
  always_comb begin
    unique case (step_r)
      S_STX:   step_after = S_CMD;
      S_CMD:   step_after = S_SUB;
      S_SUB:   step_after = S_CNT;
      S_CNT:   step_after = S_LO;
      S_LO:    step_after = S_HI;
      S_HI:    step_after = S_CRCL;
      S_CRCL:  step_after = S_CRCH;
      S_CRCH:  step_after = S_ETX;
      S_ETX:   step_after = S_STX;
      default: step_after = S_STX;
    endcase
  end

  // Escape decision and handshake with the output register.
  assign stuffable = (step_r != S_STX) && (step_r != S_ETX);
  assign special   = (cur_raw == STX) || (cur_raw == DLE) || (cur_raw == ETX);
  assign need_esc  = stuffable && special && !esc_r;
  assign can_emit  = busy_r && (!out_valid_r || out_ch.ready);
  assign advance   = can_emit && !need_esc;
  assign finishing = advance && ((step_r == S_ETX) || ((step_r == S_HI) && !job_r.last));
  assign pop_ready = !busy_r || finishing;

  // Sequencer, CRC and output register next state.
  always_comb begin
    step_nxt      = step_r;
    job_nxt       = job_r;
    busy_nxt      = busy_r;
    esc_nxt       = esc_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;

    if (can_emit) begin
      esc_nxt       = need_esc;
      out_valid_nxt = 1'b1;
      out_last_nxt  = finishing;
      out_end_nxt   = advance && (step_r == S_ETX);
      if (need_esc) begin
        out_byte_nxt = DLE;
      end else if (stuffable && (cur_raw == ETX)) begin
        out_byte_nxt = ETX_SUB;
      end else begin
        out_byte_nxt = cur_raw;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (advance) begin
      step_nxt = step_after;
      if (step_r == S_STX) begin
        crc_nxt = CRC_INIT;
      end else if (step_r == S_CMD || step_r == S_SUB || step_r == S_CNT ||
                   step_r == S_LO || step_r == S_HI) begin
        crc_nxt = crc_feed(crc_r, cur_raw);
      end
    end

    // Take the next request as soon as the current one has sent its last byte.
    if (pop_ready) begin
      busy_nxt = pop_valid;
      if (pop_valid) begin
        job_nxt  = pop_job;
        step_nxt = pop_job.first ? S_STX : S_LO;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.frame_end   = out_end_r;

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_end_r  <= out_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_STX;
      busy_r      <= 1'b0;
      esc_r       <= 1'b0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      busy_r      <= busy_nxt;
      esc_r       <= esc_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // A pending escape always sits behind a DLE held in the output register.
  a_esc_after_dle: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (out_valid_r && out_byte_r == DLE))
    else $error("escape pending without DLE in output register");

  // Trailer steps only occur for the last word of a packet.
  a_trailer_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (step_r == S_CRCL || step_r == S_CRCH || step_r == S_ETX)) |-> job_r.last)
    else $error("trailer step reached for a word that does not close the packet");

  // A closing ETX on the output is the final byte of its request.
  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_last_r && out_byte_r == ETX))
    else $error("frame end flagged on a byte that is not the final ETX");

  // A new request is only taken when the sequencer is free or finishing.
  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready && busy_r) |-> finishing)
    else $error("request taken while the previous one is still in progress");
`endif

endmodule
